// File: hdl/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, sizes and codes of the Fibonacci search key table.
// ----------------------------------------------------------------------------
package fst_pkg;

	// Table geometry and field widths.
	localparam int TABLE_DEPTH   = 128;
	localparam int KEY_WIDTH     = 32;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int INDEX_WIDTH   = 7;
	localparam int STATUS_WIDTH  = 2;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	// Every Fibonacci number in use is below twice the depth.
	localparam int FIB_W  = CNT_W + 1;
	localparam int SUM_W  = FIB_W + 1;

	// Stream beat widths, rounded up to whole bytes.
	localparam int IN_DATA_W  = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((INDEX_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - INDEX_WIDTH - PAYLOAD_WIDTH;

	// Operation codes carried in the input tuser.
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Result codes carried in the output tuser.
	localparam logic [STATUS_WIDTH-1:0] STATUS_FOUND     = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] STATUS_APPENDED  = 2'd2;
	localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd3;

	// k-th Fibonacci number, F0 = 0, F1 = 1; evaluated at elaboration only.
	function automatic int fib_num(input int k);
		int a;
		int b;
		int t;
		a = 0;
		b = 1;
		for (int i = 0; i < k; i++) begin
			t = a + b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Smallest index k >= 2 whose Fibonacci number covers the given depth.
	function automatic int fib_cover(input int depth);
		int k;
		k = 2;
		while (fib_num(k) < depth) begin
			k++;
		end
		return k;
	endfunction

	localparam int FIB_N = fib_cover(TABLE_DEPTH) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_REPLY
	} fst_state_t;

	// Write request towards the entry store.
	typedef struct packed {
		logic                     en;
		logic [ADDR_W-1:0]        addr;
		logic [KEY_WIDTH-1:0]     key;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} fst_wr_t;

endpackage

// File: hdl/fst_store.sv
// ----------------------------------------------------------------------------
// fst_store
// Key and payload memories: one write port, one shared read address and
// registered read data.
// ----------------------------------------------------------------------------
module fst_store (
	input  logic                              clk,
	input  fst_pkg::fst_wr_t                  wr,
	input  logic [fst_pkg::ADDR_W-1:0]        rd_addr,
	output logic [fst_pkg::KEY_WIDTH-1:0]     rd_key,
	output logic [fst_pkg::PAYLOAD_WIDTH-1:0] rd_payload
);

	logic [fst_pkg::KEY_WIDTH-1:0]     key_mem [fst_pkg::TABLE_DEPTH];
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] payload_mem [fst_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr]     <= wr.key;
			payload_mem[wr.addr] <= wr.payload;
		end
	end

	// Both words of an entry are fetched together, so a hit needs no second read.
	always_ff @(posedge clk) begin
		rd_key     <= key_mem[rd_addr];
		rd_payload <= payload_mem[rd_addr];
	end

endmodule

// File: hdl/fibonacci_search_table.sv
// ----------------------------------------------------------------------------
// fibonacci_search_table
// Ascending key table with append and Fibonacci search over stream channels.
// ----------------------------------------------------------------------------
// Usage. Input beats arrive on the s_ channel: tuser selects append (0) or
// search (1), tdata carries the key and, for an append, the payload word.
// Every input beat yields exactly one result beat on the m_ channel: tuser
// carries the status (found, not found, appended, table full) and tdata the
// entry index and, on a hit, the stored payload.
// An append is written in the cycle it is accepted; its result passes the
// result register and then the output register. A search probes the key
// memory, whose read data is registered, once per probe state: at most ten
// probes for a table of 128 entries, then at most one final check, and a
// reply state that hands the result to the output register. The block
// works on one beat at a time and takes the next one as soon as the
// result has moved to the output register, even while that result still
// waits for m_tready.
// Reset empties the table by clearing the entry count; the memories are not
// cleared, since only entries below the count are ever read. While the
// receiver stalls, the result is held and the block waits with the following
// result until the output register is free.
// ----------------------------------------------------------------------------
module fibonacci_search_table (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input channel.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata: key [31:0], payload [63:32]
	input  logic [fst_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: func [0]
	input  logic                               s_tuser,
	// Result channel.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata: index [6:0], found_payload [38:7], zero padding [39]
	output logic [fst_pkg::OUT_DATA_W-1:0]     m_tdata,
	// tuser: status [1:0]
	output logic [fst_pkg::STATUS_WIDTH-1:0]   m_tuser
);

	// Control state.
	fst_pkg::fst_state_t state_q;
	fst_pkg::fst_state_t state_d;
	logic [fst_pkg::CNT_W-1:0] count_q;

	// Search walk: the Fibonacci window (f, f1, f2), the lower bound of the
	// remaining range (one past the offset) and the index under probe.
	logic [fst_pkg::KEY_WIDTH-1:0] key_q;
	logic [fst_pkg::FIB_W-1:0]     f_q;
	logic [fst_pkg::FIB_W-1:0]     f1_q;
	logic [fst_pkg::FIB_W-1:0]     f2_q;
	logic [fst_pkg::CNT_W-1:0]     base_q;
	logic [fst_pkg::ADDR_W-1:0]    probe_q;

	// Result waiting to move to the output register.
	logic [fst_pkg::STATUS_WIDTH-1:0]  res_status_q;
	logic [fst_pkg::INDEX_WIDTH-1:0]   res_index_q;
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] res_payload_q;
	logic [fst_pkg::STATUS_WIDTH-1:0]  res_status_d;
	logic [fst_pkg::INDEX_WIDTH-1:0]   res_index_d;
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] res_payload_d;

	// Output register.
	logic                              m_valid_q;
	logic [fst_pkg::STATUS_WIDTH-1:0]  m_status_q;
	logic [fst_pkg::INDEX_WIDTH-1:0]   m_index_q;
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] m_payload_q;

	// Input fields.
	logic                              in_func;
	logic [fst_pkg::KEY_WIDTH-1:0]     in_key;
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] in_payload;
	logic                              in_accept;
	logic                              out_free;

	// Memory interface.
	fst_pkg::fst_wr_t                  wr;
	logic [fst_pkg::ADDR_W-1:0]        rd_addr;
	logic [fst_pkg::KEY_WIDTH-1:0]     rd_key;
	logic [fst_pkg::PAYLOAD_WIDTH-1:0] rd_payload;

	// Walk step.
	logic                          key_lt;
	logic                          key_gt;
	logic                          key_eq;
	logic [fst_pkg::FIB_W-1:0]     init_f;
	logic [fst_pkg::FIB_W-1:0]     init_f1;
	logic [fst_pkg::FIB_W-1:0]     init_f2;
	logic [fst_pkg::FIB_W-1:0]     w_f;
	logic [fst_pkg::FIB_W-1:0]     w_f1;
	logic [fst_pkg::FIB_W-1:0]     w_f2;
	logic [fst_pkg::CNT_W-1:0]     w_base;
	logic [fst_pkg::SUM_W-1:0]     probe_sum;
	logic [fst_pkg::SUM_W-1:0]     last_idx;
	logic [fst_pkg::SUM_W-1:0]     probe_idx;
	logic                          go_probe;
	logic                          go_check;
	logic                          walk_load;

	assign in_key     = s_tdata[fst_pkg::KEY_WIDTH-1:0];
	assign in_payload = s_tdata[fst_pkg::KEY_WIDTH +: fst_pkg::PAYLOAD_WIDTH];
	assign in_func    = s_tuser;

	assign s_tready  = (state_q == fst_pkg::ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{fst_pkg::OUT_PAD_W{1'b0}}, m_payload_q, m_index_q};

	fst_store u_store (
		.clk        (clk),
		.wr         (wr),
		.rd_addr    (rd_addr),
		.rd_key     (rd_key),
		.rd_payload (rd_payload)
	);

	// Starting window: the smallest Fibonacci number F(k), k >= 2, that is not
	// below the entry count. Each compare is independent; the smallest k wins.
	always_comb begin
		init_f  = fst_pkg::FIB_W'(fst_pkg::fib_num(fst_pkg::FIB_N - 1));
		init_f1 = fst_pkg::FIB_W'(fst_pkg::fib_num(fst_pkg::FIB_N - 2));
		init_f2 = fst_pkg::FIB_W'(fst_pkg::fib_num(fst_pkg::FIB_N - 3));
		for (int k = fst_pkg::FIB_N - 1; k >= 2; k--) begin
			if (fst_pkg::FIB_W'(count_q) <= fst_pkg::FIB_W'(fst_pkg::fib_num(k))) begin
				init_f  = fst_pkg::FIB_W'(fst_pkg::fib_num(k));
				init_f1 = fst_pkg::FIB_W'(fst_pkg::fib_num(k - 1));
				init_f2 = fst_pkg::FIB_W'(fst_pkg::fib_num(k - 2));
			end
		end
	end

	assign key_lt = rd_key < key_q;
	assign key_gt = rd_key > key_q;
	assign key_eq = rd_key == key_q;

	// Next window: the starting one when a search is taken, otherwise the
	// probe result narrows it up (key below target), down (key above) or keeps it.
	always_comb begin
		w_f    = f_q;
		w_f1   = f1_q;
		w_f2   = f2_q;
		w_base = base_q;
		if (state_q == fst_pkg::ST_IDLE) begin
			w_f    = init_f;
			w_f1   = init_f1;
			w_f2   = init_f2;
			w_base = '0;
		end else if (key_lt) begin
			w_f    = f1_q;
			w_f1   = f2_q;
			w_f2   = f1_q - f2_q;
			w_base = fst_pkg::CNT_W'(probe_q) + fst_pkg::CNT_W'(1);
		end else if (key_gt) begin
			w_f    = f2_q;
			w_f1   = f1_q - f2_q;
			w_f2   = f2_q - (f1_q - f2_q);
		end
	end

	// Next probe index, clamped to the last filled entry.
	assign probe_sum = fst_pkg::SUM_W'(w_base) + fst_pkg::SUM_W'(w_f2) - fst_pkg::SUM_W'(1);
	assign last_idx  = fst_pkg::SUM_W'(count_q) - fst_pkg::SUM_W'(1);
	assign probe_idx = (probe_sum > last_idx) ? last_idx : probe_sum;
	assign go_probe  = w_f > fst_pkg::FIB_W'(1);
	assign go_check  = (w_f1 != '0) && (w_base < count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fst_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (in_func == fst_pkg::FUNC_SEARCH && go_probe) begin
						state_d = fst_pkg::ST_PROBE;
					end else if (in_func == fst_pkg::FUNC_SEARCH && go_check) begin
						state_d = fst_pkg::ST_CHECK;
					end else begin
						state_d = fst_pkg::ST_REPLY;
					end
				end
			end
			fst_pkg::ST_PROBE: begin
				if (key_eq) begin
					state_d = fst_pkg::ST_REPLY;
				end else if (go_probe) begin
					state_d = fst_pkg::ST_PROBE;
				end else if (go_check) begin
					state_d = fst_pkg::ST_CHECK;
				end else begin
					state_d = fst_pkg::ST_REPLY;
				end
			end
			fst_pkg::ST_CHECK: begin
				state_d = fst_pkg::ST_REPLY;
			end
			fst_pkg::ST_REPLY: begin
				if (out_free) begin
					state_d = fst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fst_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath controls and the result of the current state.
	always_comb begin
		wr.en         = 1'b0;
		wr.addr       = count_q[fst_pkg::ADDR_W-1:0];
		wr.key        = in_key;
		wr.payload    = in_payload;
		rd_addr       = go_probe ? probe_idx[fst_pkg::ADDR_W-1:0]
		                         : w_base[fst_pkg::ADDR_W-1:0];
		walk_load     = 1'b0;
		res_status_d  = fst_pkg::STATUS_NOT_FOUND;
		res_index_d   = '0;
		res_payload_d = '0;
		unique case (state_q)
			fst_pkg::ST_IDLE: begin
				walk_load = 1'b1;
				if (in_func == fst_pkg::FUNC_APPEND) begin
					if (count_q == fst_pkg::CNT_W'(fst_pkg::TABLE_DEPTH)) begin
						res_status_d = fst_pkg::STATUS_FULL;
					end else begin
						wr.en        = in_accept;
						res_status_d = fst_pkg::STATUS_APPENDED;
						res_index_d  = fst_pkg::INDEX_WIDTH'(count_q);
					end
				end
			end
			fst_pkg::ST_PROBE, fst_pkg::ST_CHECK: begin
				walk_load = (state_q == fst_pkg::ST_PROBE);
				if (key_eq) begin
					res_status_d  = fst_pkg::STATUS_FOUND;
					res_index_d   = fst_pkg::INDEX_WIDTH'(probe_q);
					res_payload_d = rd_payload;
				end
			end
			fst_pkg::ST_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fst_pkg::ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr.en) begin
				count_q <= count_q + fst_pkg::CNT_W'(1);
			end
			if (state_q == fst_pkg::ST_REPLY && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Walk and result registers carry data only and need no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			key_q <= in_key;
		end
		if (walk_load) begin
			f_q     <= w_f;
			f1_q    <= w_f1;
			f2_q    <= w_f2;
			base_q  <= w_base;
			probe_q <= rd_addr;
		end
		if (state_q != fst_pkg::ST_REPLY) begin
			res_status_q  <= res_status_d;
			res_index_q   <= res_index_d;
			res_payload_q <= res_payload_d;
		end
		if (state_q == fst_pkg::ST_REPLY && out_free) begin
			m_status_q  <= res_status_q;
			m_index_q   <= res_index_q;
			m_payload_q <= res_payload_q;
		end
	end

	// The entry count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fst_pkg::CNT_W'(fst_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// A probe only runs while the Fibonacci window is still open.
	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fst_pkg::ST_PROBE |-> f_q > fst_pkg::FIB_W'(1))
		else $error("probe with a closed Fibonacci window");

	// An accepted append into a table with room grows it by exactly one.
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_func == fst_pkg::FUNC_APPEND
		&& count_q != fst_pkg::CNT_W'(fst_pkg::TABLE_DEPTH)
		|=> count_q == $past(count_q) + fst_pkg::CNT_W'(1))
		else $error("append did not advance the entry count");

	// A hit always names a filled entry.
	a_hit_filled: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_status_q == fst_pkg::STATUS_FOUND
		|-> fst_pkg::CNT_W'(m_index_q) < count_q)
		else $error("hit reported beyond the filled entries");

endmodule
